// ----- hdl/lpm_route_and_arp_lookup_unit_defines.svh -----
// assertion macros shared by the lookup unit
`ifndef LPM_ROUTE_AND_ARP_LOOKUP_UNIT_DEFINES_SVH
`define LPM_ROUTE_AND_ARP_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpm lookup unit: same-cycle check failed");

// next-cycle implication, disabled during reset
`define LPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpm lookup unit: next-cycle check failed");

`endif

// ----- hdl/lpm_pkg.sv -----
// types, codes and helper functions of the route and arp lookup unit
package lpm_pkg;

   // item modes
   localparam logic [1:0] MODE_ROUTE_WRITE = 2'd0;
   localparam logic [1:0] MODE_ARP_WRITE   = 2'd1;
   localparam logic [1:0] MODE_LOOKUP      = 2'd2;

   // configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam int COUNT_W    = 7;
   localparam logic [0:0] REG_ROUTE_COUNT = 1'b0;
   localparam logic [0:0] REG_ARP_COUNT   = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  entry_index;
      logic [31:0] entry_address;
      logic [31:0] entry_mask;
      logic [31:0] entry_next_hop;
      logic [3:0]  entry_port;
      logic [47:0] entry_mac;
      logic [31:0] lookup_address;
   } req_type;

   typedef struct packed {
      logic        route_found;
      logic        arp_found;
      logic [31:0] hop_address;
      logic [3:0]  out_port;
      logic [47:0] hop_mac;
   } rsp_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] hop;
      logic [3:0]  port;
   } route_entry_type;

   typedef struct packed {
      logic [31:0] address;
      logic [47:0] mac;
   } arp_entry_type;

   // controller to datapath
   typedef struct packed {
      logic accept_ready;
      logic load_req;
      logic do_write;
      logic scan_start;
      logic route_scan;
      logic arp_scan;
      logic load_result;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic route_done;
      logic arp_done;
      logic route_found;
   } status_type;

   // thermometer of the leading run of ones; a longer run sets a superset of bits
   function automatic logic [31:0] lead_therm(input logic [31:0] m);
      logic [31:0] t;
      t = '0;
      for (int i = 0; i < 32; i++) begin
         t[i] = &(m | ((32'h1 << i) - 32'h1));
      end
      return t;
   endfunction

endpackage

// ----- hdl/lpm_ram.sv -----
// generic simple dual-port ram with registered read
module lpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lpm_ctrl.sv -----
// sequencing state machine of the lookup unit
module lpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   input  logic                out_free,
   input  lpm_pkg::status_type status,
   output lpm_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WRITE  = 5'b00010,
      ST_ROUTE  = 5'b00100,
      ST_ARP    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_mode == lpm_pkg::MODE_LOOKUP) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_ROUTE;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cmd.do_write = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_ROUTE: begin
            cmd.route_scan = 1'b1;
            if (status.route_done) begin
               if (status.route_found) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_ARP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_ARP: begin
            cmd.arp_scan = 1'b1;
            if (status.arp_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/lpm_dpath.sv -----
// table memories, scan counter and best-match registers of the lookup unit
module lpm_dpath #(
   parameter int ROUTE_DEPTH = 64,
   parameter int ARP_DEPTH   = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpm_pkg::cmd_type            cmd,
   input  lpm_pkg::req_type            req_data,
   input  logic [lpm_pkg::COUNT_W-1:0] route_count,
   input  logic [lpm_pkg::COUNT_W-1:0] arp_count,
   output lpm_pkg::status_type         status,
   output lpm_pkg::rsp_type            result
);

   localparam int RA   = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
   localparam int AA   = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
   localparam int MAXD = (ROUTE_DEPTH > ARP_DEPTH) ? ROUTE_DEPTH : ARP_DEPTH;
   localparam int SW   = $clog2(MAXD + 1);
   localparam int RW   = $bits(lpm_pkg::route_entry_type);
   localparam int AWD  = $bits(lpm_pkg::arp_entry_type);

   lpm_pkg::req_type         req_ff;
   logic [SW-1:0]            scan_idx_ff, scan_idx_in;
   logic                     route_rv_ff, arp_rv_ff;
   logic                     found_ff, found_in;
   logic                     arp_found_ff, arp_found_in;
   logic [31:0]              best_th_ff, best_th_in;
   logic [31:0]              hop_ff, hop_in;
   logic [3:0]               port_ff, port_in;
   logic [47:0]              mac_ff, mac_in;

   logic [SW-1:0]            route_lim, arp_lim;
   logic                     route_issue, arp_issue;
   logic                     route_we, arp_we;
   lpm_pkg::route_entry_type route_wr, route_rd;
   lpm_pkg::arp_entry_type   arp_wr, arp_rd;
   logic [RW-1:0]            route_rd_bits;
   logic [AWD-1:0]           arp_rd_bits;
   logic [31:0]              cand_th;
   logic                     route_hit, route_better;

   // counts clamped to the table depths
   always_comb begin
      if (32'(route_count) > ROUTE_DEPTH) begin
         route_lim = SW'(ROUTE_DEPTH);
      end else begin
         route_lim = SW'(route_count);
      end
      if (32'(arp_count) > ARP_DEPTH) begin
         arp_lim = SW'(ARP_DEPTH);
      end else begin
         arp_lim = SW'(arp_count);
      end
   end

   // write enables, slots beyond the depth are dropped
   assign route_we = cmd.do_write && (req_ff.mode == lpm_pkg::MODE_ROUTE_WRITE)
                     && (32'(req_ff.entry_index) < ROUTE_DEPTH);
   assign arp_we   = cmd.do_write && (req_ff.mode == lpm_pkg::MODE_ARP_WRITE)
                     && (32'(req_ff.entry_index) < ARP_DEPTH);

   assign route_wr.prefix = req_ff.entry_address;
   assign route_wr.mask   = req_ff.entry_mask;
   assign route_wr.hop    = req_ff.entry_next_hop;
   assign route_wr.port   = req_ff.entry_port;
   assign arp_wr.address  = req_ff.entry_address;
   assign arp_wr.mac      = req_ff.entry_mac;

   // one read issued per cycle while entries remain
   assign route_issue = cmd.route_scan && (scan_idx_ff < route_lim);
   assign arp_issue   = cmd.arp_scan && (scan_idx_ff < arp_lim);

   lpm_ram #(.WIDTH(RW), .DEPTH(ROUTE_DEPTH)) u_route_ram (
      .clock   (clock),
      .wr_en   (route_we),
      .wr_addr (RA'(req_ff.entry_index)),
      .wr_data (route_wr),
      .rd_addr (RA'(scan_idx_ff)),
      .rd_data (route_rd_bits)
   );

   lpm_ram #(.WIDTH(AWD), .DEPTH(ARP_DEPTH)) u_arp_ram (
      .clock   (clock),
      .wr_en   (arp_we),
      .wr_addr (AA'(req_ff.entry_index)),
      .wr_data (arp_wr),
      .rd_addr (AA'(scan_idx_ff)),
      .rd_data (arp_rd_bits)
   );

   assign route_rd = lpm_pkg::route_entry_type'(route_rd_bits);
   assign arp_rd   = lpm_pkg::arp_entry_type'(arp_rd_bits);

   // route compare, longer leading run wins, ties keep the earlier slot
   assign cand_th      = lpm_pkg::lead_therm(route_rd.mask);
   assign route_hit    = route_rv_ff
                         && ((req_ff.lookup_address & route_rd.mask) == route_rd.prefix);
   assign route_better = !found_ff || ((cand_th & ~best_th_ff) != 32'h0);

   // best-match and arp-match update
   always_comb begin
      found_in     = found_ff;
      best_th_in   = best_th_ff;
      hop_in       = hop_ff;
      port_in      = port_ff;
      arp_found_in = arp_found_ff;
      mac_in       = mac_ff;
      if (cmd.load_req) begin
         found_in     = 1'b0;
         arp_found_in = 1'b0;
      end else begin
         if (route_hit && route_better) begin
            found_in   = 1'b1;
            best_th_in = cand_th;
            hop_in     = route_rd.hop;
            port_in    = route_rd.port;
         end
         if (arp_rv_ff && !arp_found_ff && (arp_rd.address == hop_ff)) begin
            arp_found_in = 1'b1;
            mac_in       = arp_rd.mac;
         end
      end
   end

   // scan counter
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (route_issue || arp_issue) begin
         scan_idx_in = scan_idx_ff + SW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         route_rv_ff  <= 1'b0;
         arp_rv_ff    <= 1'b0;
         found_ff     <= 1'b0;
         arp_found_ff <= 1'b0;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         route_rv_ff  <= route_issue;
         arp_rv_ff    <= arp_issue;
         found_ff     <= found_in;
         arp_found_ff <= arp_found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      best_th_ff <= best_th_in;
      hop_ff     <= hop_in;
      port_ff    <= port_in;
      mac_ff     <= mac_in;
   end

   assign status.route_done  = (scan_idx_ff >= route_lim) && !route_rv_ff;
   assign status.arp_done    = (scan_idx_ff >= arp_lim) && !arp_rv_ff;
   assign status.route_found = found_ff;

   assign result.route_found = found_ff;
   assign result.arp_found   = found_ff && arp_found_ff;
   assign result.hop_address = found_ff ? hop_ff : 32'h0;
   assign result.out_port    = found_ff ? port_ff : 4'h0;
   assign result.hop_mac     = (found_ff && arp_found_ff) ? mac_ff : 48'h0;

endmodule

// ----- hdl/lpm_route_and_arp_lookup_unit.sv -----
// top level of the ipv4 longest-prefix-match route and arp lookup unit
`include "lpm_route_and_arp_lookup_unit_defines.svh"

// Handles one item at a time. A route or arp write passes through a write
// state and a finish state before the next possible transfer in. A lookup
// reads the route table one entry per cycle through the single read port of
// its ram, then, if a route matched, the arp table the same way; the arp
// phase is skipped when no route matched. The result sits in an output
// register, so a stalled result does not hold up the next transfer in; the
// following result waits for that register to empty. Table contents are
// not cleared by reset and must be written before use; route_count and
// arp_count are written over the csr port, and the user must write them only
// while idle; the block itself does not enforce this.
module lpm_route_and_arp_lookup_unit #(
   parameter int ROUTE_DEPTH = 64,
   parameter int ARP_DEPTH   = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lpm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lpm_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lpm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   lpm_pkg::cmd_type             cmd;
   lpm_pkg::status_type          status;
   lpm_pkg::rsp_type             result;
   lpm_pkg::rsp_type             rsp_data_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;
   logic [lpm_pkg::COUNT_W-1:0]  route_count_ff, route_count_in;
   logic [lpm_pkg::COUNT_W-1:0]  arp_count_ff, arp_count_in;
   logic                         csr_wr;
   logic [0:0]                   csr_index;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[lpm_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      route_count_in = route_count_ff;
      arp_count_in   = arp_count_ff;
      if (csr_wr) begin
         case (csr_index)
            lpm_pkg::REG_ROUTE_COUNT: route_count_in = csr_pwdata[lpm_pkg::COUNT_W-1:0];
            lpm_pkg::REG_ARP_COUNT:   arp_count_in   = csr_pwdata[lpm_pkg::COUNT_W-1:0];
            default:                  route_count_in = route_count_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lpm_pkg::REG_ROUTE_COUNT: csr_prdata = 32'(route_count_ff);
         lpm_pkg::REG_ARP_COUNT:   csr_prdata = 32'(arp_count_ff);
         default:                  csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff <= '0;
         arp_count_ff   <= '0;
      end else begin
         route_count_ff <= route_count_in;
         arp_count_ff   <= arp_count_in;
      end
   end

   // sequencing and datapath
   lpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   lpm_dpath #(
      .ROUTE_DEPTH (ROUTE_DEPTH),
      .ARP_DEPTH   (ARP_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .route_count (route_count_ff),
      .arp_count   (arp_count_ff),
      .status      (status),
      .result      (result)
   );

   assign req_stall = !cmd.accept_ready;

   // output register, freed by a transfer out
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks on the sequencing
   `LPM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `LPM_ASSERT_NOW(a_load_needs_room, clock, reset, cmd.load_result, out_free)
   `LPM_ASSERT_NOW(a_arp_implies_route, clock, reset, rsp_valid && rsp_data.arp_found,
                   rsp_data.route_found)

endmodule
